FILE: design/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, constants and helpers of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLS   = 80;
	localparam int ROWS   = 25;
	localparam int CELLS  = COLS * ROWS;

	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int ADDR_W = 11;
	localparam int CELL_W = 16;

	localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] CELL_END   = ADDR_W'(CELLS);
	localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'(CELLS - COLS);
	localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(COLS);

	// ceil(2^16 / m): exact quotient of any byte for every modulus below 256
	localparam logic [16:0] COL_RECIP = 17'((65536 + COLS - 1) / COLS);
	localparam logic [16:0] ROW_RECIP = 17'((65536 + ROWS - 1) / ROWS);

	typedef enum logic [1:0] {
		ACT_PUT    = 2'd0,
		ACT_CLEAR  = 2'd1,
		ACT_SETCUR = 2'd2,
		ACT_READ   = 2'd3
	} action_t;

	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LAST  = 8'h7F;

	localparam logic REG_FG = 1'b0;
	localparam logic REG_BG = 1'b1;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic [CELL_W-1:0] data;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [ADDR_W-1:0] offset;
	} result_t;

	function automatic logic [ADDR_W-1:0] cell_offset(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		return ADDR_W'(row) * ROW_STEP + ADDR_W'(col);
	endfunction

	// remainder by a constant modulus: quotient by reciprocal multiply, then one subtract
	function automatic logic [7:0] mod_const(input logic [7:0] v, input logic [16:0] recip,
		input logic [7:0] m);
		logic [23:0] p;
		logic [7:0]  q;
		logic [15:0] r;
		p = 24'(v) * 24'(recip);
		q = p[23:16];
		r = 16'(v) - 16'(q) * 16'(m);
		return r[7:0];
	endfunction

endpackage
`default_nettype wire

FILE: design/tcw_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: design/tcw_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_engine
// Cursor registers, action sequencer, clear and scroll sweeps, result register.
// ----------------------------------------------------------------------------
module tcw_engine
	import tcw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_stall,
	input  wire logic [1:0]        action,
	input  wire logic [7:0]        char_code,
	input  wire logic [7:0]        new_col,
	input  wire logic [7:0]        new_row,
	input  wire logic [ADDR_W-1:0] read_address,
	input  wire logic [7:0]        attr,
	output      ram_req_t          ram,
	input  wire logic [CELL_W-1:0] rd_data,
	output      logic              out_valid,
	input  wire logic              out_stall,
	output      result_t           res
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_FINISH = 4'b0010,
		ST_CLEAR  = 4'b0100,
		ST_SCROLL = 4'b1000
	} state_t;

	state_t            state_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] ptr_q;
	logic              cell_sel_q;
	logic              out_valid_q;
	result_t           res_q;

	logic              wr_v_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic              blank_s1;

	logic              accept;
	action_t           act;
	logic [CELL_W-1:0] blank;
	logic [ADDR_W-1:0] cur_idx;
	logic              out_free;
	logic [7:0]        set_col;
	logic [7:0]        set_row;

	logic [COL_W-1:0]  pc_col;
	logic [ROW_W:0]    pc_row;
	logic              pc_write;
	logic              pc_scroll;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign act      = action_t'(action);
	assign blank    = {attr, CH_SPACE};
	assign cur_idx  = cell_offset(row_q, col_q);
	assign out_free = !out_valid_q || !out_stall;
	assign set_col  = mod_const(new_col, COL_RECIP, 8'(COLS));
	assign set_row  = mod_const(new_row, ROW_RECIP, 8'(ROWS));

	// cursor motion of put char, including wrap and the scroll decision
	always_comb begin
		pc_col    = col_q;
		pc_row    = {1'b0, row_q};
		pc_write  = 1'b0;
		pc_scroll = 1'b0;
		case (char_code)
			CH_BS: begin
				if (col_q != '0) begin
					pc_col = col_q - COL_W'(1);
				end
			end
			CH_TAB: pc_col = (col_q + COL_W'(8)) & ~COL_W'(7);
			CH_CR:  pc_col = '0;
			CH_LF: begin
				pc_col = '0;
				pc_row = pc_row + (ROW_W+1)'(1);
			end
			default: begin
				if (char_code >= CH_SPACE && char_code <= CH_LAST) begin
					pc_write = (cur_idx < CELL_END);
					pc_col   = col_q + COL_W'(1);
				end
			end
		endcase
		if (pc_col >= COL_W'(COLS)) begin
			pc_col = '0;
			pc_row = pc_row + (ROW_W+1)'(1);
		end
		if (pc_row >= (ROW_W+1)'(ROWS)) begin
			pc_scroll = 1'b1;
			pc_row    = (ROW_W+1)'(ROWS - 1);
		end
	end

	always_comb begin
		ram = '0;
		if (accept && act == ACT_PUT && pc_write) begin
			ram.we    = 1'b1;
			ram.waddr = cur_idx;
			ram.wdata = {attr, char_code};
		end
		if (accept && act == ACT_READ && read_address < CELL_END) begin
			ram.re    = 1'b1;
			ram.raddr = read_address;
		end
		if (state_q == ST_CLEAR) begin
			ram.we    = 1'b1;
			ram.waddr = ptr_q;
			ram.wdata = blank;
		end
		if (state_q == ST_SCROLL && ptr_q < BOTTOM_ROW) begin
			ram.re    = 1'b1;
			ram.raddr = ptr_q + ROW_STEP;
		end
		if (wr_v_s1) begin
			ram.we    = 1'b1;
			ram.waddr = wr_addr_s1;
			ram.wdata = blank_s1 ? blank : rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			ptr_q       <= '0;
			wr_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ptr_q <= '0;
						case (act)
							ACT_PUT: begin
								col_q   <= pc_col;
								row_q   <= pc_row[ROW_W-1:0];
								state_q <= pc_scroll ? ST_SCROLL : ST_FINISH;
							end
							ACT_CLEAR: state_q <= ST_CLEAR;
							ACT_SETCUR: begin
								col_q   <= set_col[COL_W-1:0];
								row_q   <= set_row[ROW_W-1:0];
								state_q <= ST_FINISH;
							end
							default: state_q <= ST_FINISH;
						endcase
					end
				end
				ST_CLEAR: begin
					ptr_q <= ptr_q + ADDR_W'(1);
					if (ptr_q == CELL_LAST) begin
						state_q <= ST_FINISH;
					end
				end
				ST_SCROLL: begin
					if (ptr_q != CELL_END) begin
						wr_v_s1 <= 1'b1;
						ptr_q   <= ptr_q + ADDR_W'(1);
					end else begin
						// drain the last write-back
						wr_v_s1 <= 1'b0;
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_sel_q <= (act == ACT_READ) && (read_address < CELL_END);
		end
		if (state_q == ST_SCROLL) begin
			wr_addr_s1 <= ptr_q;
			blank_s1   <= (ptr_q >= BOTTOM_ROW);
		end
		if (state_q == ST_FINISH && out_free) begin
			res_q.data   <= cell_sel_q ? rd_data : '0;
			res_q.col    <= col_q;
			res_q.row    <= row_q;
			res_q.offset <= cur_idx;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != ST_IDLE))
		else $error("accepted transfer did not start work");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram.we |-> (ram.waddr < CELL_END))
		else $error("screen write outside the cell range");

	a_wb_only_in_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		wr_v_s1 |-> (state_q == ST_SCROLL))
		else $error("scroll write-back outside the scroll sweep");

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(ram.we && ram.re) |-> (ram.waddr != ram.raddr))
		else $error("read and write of the same cell in one cycle");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result loaded outside the finish step");

endmodule
`default_nettype wire

FILE: design/text_console_writer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_top
// 80x25 text console: put char, clear, set cursor and read cell on one
// screen RAM, with foreground and background colour registers.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_stall    | action, char_code, new_col,
//          |           |                        | new_row, read_address
//  out     | output    | out_valid / out_stall  | cell_value, cursor_col,
//          |           |                        | cursor_row, cursor_offset
//  apb     | input     | psel, penable, pready  | paddr, pwdata, prdata
//
// Put char, set cursor and read cell: the accept cycle does the cursor update and
// any screen RAM access, then the finish step loads the result once the output is free.
// Clear sweeps the RAM write port one cell a cycle over every screen cell.
// A put char that scrolls adds a read-ahead/write-back pass before the finish step.
// No clearing pass after reset; the screen is undefined until cleared or written.
// A stalled result holds in the output register while the next transfer is taken.
// ----------------------------------------------------------------------------
module text_console_writer_top
	import tcw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_stall,
	input  wire logic [1:0]        action,
	input  wire logic [7:0]        char_code,
	input  wire logic [7:0]        new_col,
	input  wire logic [7:0]        new_row,
	input  wire logic [ADDR_W-1:0] read_address,
	output      logic              out_valid,
	input  wire logic              out_stall,
	output      logic [CELL_W-1:0] cell_value,
	output      logic [COL_W-1:0]  cursor_col,
	output      logic [ROW_W-1:0]  cursor_row,
	output      logic [ADDR_W-1:0] cursor_offset,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output      logic [31:0]       prdata,
	output      logic              pready
);

	logic [3:0]        fg_q;
	logic [3:0]        bg_q;
	ram_req_t          ram;
	logic [CELL_W-1:0] rd_data;
	result_t           res;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= 4'd7;
			bg_q <= 4'd0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_FG) begin
				fg_q <= pwdata[3:0];
			end else begin
				bg_q <= pwdata[3:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_BG) ? {28'd0, bg_q} : {28'd0, fg_q};

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (ram.we),
		.waddr(ram.waddr),
		.wdata(ram.wdata),
		.re   (ram.re),
		.raddr(ram.raddr),
		.rdata(rd_data)
	);

	tcw_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.char_code   (char_code),
		.new_col     (new_col),
		.new_row     (new_row),
		.read_address(read_address),
		.attr        ({bg_q, fg_q}),
		.ram         (ram),
		.rd_data     (rd_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.res         (res)
	);

	assign cell_value    = res.data;
	assign cursor_col    = res.col;
	assign cursor_row    = res.row;
	assign cursor_offset = res.offset;

endmodule
`default_nettype wire
